/* design/gda_pkg.sv */
// ----------------------------------------------------------------------------
// gda_pkg - shared definitions for the Gregorian date adder
// Field widths, reciprocal constants for the small divisions and the
// month-length lookup used by the day stepper.
// ----------------------------------------------------------------------------
package gda_pkg;

   // field widths
   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int SYEAR_W  = 14;
   localparam int AYEAR_W  = 14;
   localparam int AMONTH_W = 12;
   localparam int ADAY_W   = 15;
   localparam int YEAR_W   = 16;

   // packed beat widths
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 32;

   // month index (month - 1 + add_months) and its quotient by twelve
   localparam int MIDX_W = 13;
   // year modulo 25, tracked alongside the year
   localparam int M25_W  = 5;

   // reciprocals, both used with a right shift of RECIP_SHIFT
   // 5462 / 2^16 is exact for floor(x / 12) on 13-bit x
   // 2621 / 2^16 gives floor(x / 25) or one less on 16-bit x
   localparam int RECIP_SHIFT = 16;
   localparam int MUL_B_W     = 13;
   localparam int MUL_P_W     = YEAR_W + MUL_B_W;
   localparam logic [MUL_B_W-1:0] RECIP_12 = 13'd5462;
   localparam logic [MUL_B_W-1:0] RECIP_25 = 13'd2621;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [M25_W-1:0]   M25_LAST  = 5'd24;
   localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;

   // Leap rule: y%4==0 and y%100!=0, or y%400==0.
   // With y%100==0 <=> (y%4==0 && y%25==0) and y%400==0 <=> (y%16==0 && y%25==0).
   function automatic logic is_leap(input logic [3:0] y_low, input logic [M25_W-1:0] m25);
      logic m25_zero;
      m25_zero = (m25 == '0);
      return ((y_low[1:0] == 2'd0) && !m25_zero) || ((y_low == 4'd0) && m25_zero);
   endfunction

   // days in month; codes outside 1..12 give zero
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] d;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
         4'd2:                                       d = leap ? 5'd29 : 5'd28;
         default:                                    d = 5'd0;
      endcase
      return d;
   endfunction

endpackage

/* design/gregorian_date_adder.sv */
// Requests are taken only in idle; the day stepper advances one day per cycle
//   and one shared multiplier handles both small divisions.
// A new request is taken while the previous response still waits.
// Reset (synchronous, active high) returns the sequencer to idle and drops
//   rsp_tvalid; payload registers are not cleared.
// ----------------------------------------------------------------------------
// gregorian_date_adder - add years, months and days to a Gregorian date
// Years are added, then months with carry into the year, the day is clamped
// to the month reached, and days are stepped one per cycle. Year wraps at
// 16 bits with a sticky wrap flag.
// ----------------------------------------------------------------------------
module gregorian_date_adder (
   input  logic                              clock,
   input  logic                              reset,
   // request: start_day, start_month, start_year, add_years, add_months, add_days
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [gda_pkg::REQ_DATA_W-1:0]    req_tdata,
   // response: end_day, end_month, end_year, year_wrapped, zero fill
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gda_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   // sequencer codes
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MDIV  = 3'd1;
   localparam logic [2:0] S_MADD  = 3'd2;
   localparam logic [2:0] S_YDIV  = 3'd3;
   localparam logic [2:0] S_YREM  = 3'd4;
   localparam logic [2:0] S_CLAMP = 3'd5;
   localparam logic [2:0] S_STEP  = 3'd6;

   localparam int DW = gda_pkg::DAY_W;
   localparam int MW = gda_pkg::MONTH_W;
   localparam int YW = gda_pkg::YEAR_W;
   localparam int XW = gda_pkg::MIDX_W;
   localparam int RW = gda_pkg::M25_W;

   // request fields
   logic [DW-1:0]                 in_day;
   logic [MW-1:0]                 in_month;
   logic [gda_pkg::SYEAR_W-1:0]   in_year;
   logic [gda_pkg::AYEAR_W-1:0]   in_add_y;
   logic [gda_pkg::AMONTH_W-1:0]  in_add_m;
   logic [gda_pkg::ADAY_W-1:0]    in_add_d;

   assign in_day   = req_tdata[4:0];
   assign in_month = req_tdata[8:5];
   assign in_year  = req_tdata[22:9];
   assign in_add_y = req_tdata[36:23];
   assign in_add_m = req_tdata[48:37];
   assign in_add_d = req_tdata[63:49];

   logic [2:0]                  state_ff, state_in;
   logic [DW-1:0]               day_ff, day_in;
   logic [MW-1:0]               month_ff, month_in;
   logic [YW-1:0]               year_ff, year_in;
   logic                        wrap_ff, wrap_in;
   logic [XW-1:0]               midx_ff, midx_in;
   logic [XW-1:0]               quot_ff, quot_in;
   logic [RW-1:0]               m25_ff, m25_in;
   logic [gda_pkg::ADAY_W-1:0]  cnt_ff, cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]               rsp_day_ff, rsp_day_in;
   logic [MW-1:0]               rsp_month_ff, rsp_month_in;
   logic [YW-1:0]               rsp_year_ff, rsp_year_in;
   logic                        rsp_wrap_ff, rsp_wrap_in;

   logic                        req_fire;
   logic                        out_free;
   logic [MW-1:0]               month_clamped;
   logic [YW:0]                 year_sum;
   logic [YW:0]                 year_inc;
   logic [XW-1:0]               midx_rem;
   logic [YW-1:0]               yrem_wide;
   logic [RW:0]                 yrem;
   logic                        leap;
   logic [DW-1:0]               mlen;
   logic [RW-1:0]               m25_next;

   // shared reciprocal multiplier
   logic [YW-1:0]               mul_a;
   logic [gda_pkg::MUL_B_W-1:0] mul_b;
   logic [gda_pkg::MUL_P_W-1:0] mul_p;

   assign mul_a = (state_ff == S_MDIV) ? YW'(midx_ff) : year_ff;
   assign mul_b = (state_ff == S_MDIV) ? gda_pkg::RECIP_12 : gda_pkg::RECIP_25;
   assign mul_p = gda_pkg::MUL_P_W'(mul_a) * gda_pkg::MUL_P_W'(mul_b);

   // handshake
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // month code clamp to 1..12
   always_comb begin
      if (in_month < gda_pkg::MONTH_JAN) begin
         month_clamped = gda_pkg::MONTH_JAN;
      end else if (in_month > gda_pkg::MONTH_DEC) begin
         month_clamped = gda_pkg::MONTH_DEC;
      end else begin
         month_clamped = in_month;
      end
   end

   // remainders from the registered quotients
   assign midx_rem  = midx_ff - XW'({quot_ff, 3'b000} + {quot_ff, 2'b00});
   assign yrem_wide = year_ff - YW'({quot_ff, 4'b0000} + {quot_ff, 3'b000} + quot_ff);
   assign yrem      = yrem_wide[RW:0];

   assign year_sum = {1'b0, year_ff} + (YW+1)'(quot_ff);
   assign year_inc = {1'b0, year_ff} + 1'b1;

   // calendar lookup for the current month
   assign leap = gda_pkg::is_leap(year_ff[3:0], m25_ff);
   assign mlen = gda_pkg::month_days(month_ff, leap);

   // year mod 25 after one increment; 65535 -> 0 restarts the count
   always_comb begin
      if (year_inc[YW] || (m25_ff == gda_pkg::M25_LAST)) begin
         m25_next = '0;
      end else begin
         m25_next = m25_ff + 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      wrap_in      = wrap_ff;
      midx_in      = midx_ff;
      quot_in      = quot_ff;
      m25_in       = m25_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_day_in   = rsp_day_ff;
      rsp_month_in = rsp_month_ff;
      rsp_year_in  = rsp_year_ff;
      rsp_wrap_in  = rsp_wrap_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               day_in   = in_day;
               year_in  = YW'(in_year) + YW'(in_add_y);
               wrap_in  = 1'b0;
               midx_in  = XW'(month_clamped - gda_pkg::MONTH_JAN) + XW'(in_add_m);
               cnt_in   = in_add_d;
               state_in = S_MDIV;
            end
         end
         S_MDIV: begin
            quot_in  = mul_p[gda_pkg::RECIP_SHIFT +: XW];
            state_in = S_MADD;
         end
         S_MADD: begin
            month_in = MW'(midx_rem) + gda_pkg::MONTH_JAN;
            year_in  = year_sum[YW-1:0];
            wrap_in  = wrap_ff | year_sum[YW];
            state_in = S_YDIV;
         end
         S_YDIV: begin
            quot_in  = mul_p[gda_pkg::RECIP_SHIFT +: XW];
            state_in = S_YREM;
         end
         S_YREM: begin
            // estimate is exact or one short, so one correction suffices
            if (yrem >= (RW+1)'(25)) begin
               m25_in = RW'(yrem - (RW+1)'(25));
            end else begin
               m25_in = yrem[RW-1:0];
            end
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            if (day_ff == '0) begin
               day_in = gda_pkg::DAY_FIRST;
            end else if (day_ff > mlen) begin
               day_in = mlen;
            end
            state_in = S_STEP;
         end
         S_STEP: begin
            if (cnt_ff == '0) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_day_in   = day_ff;
                  rsp_month_in = month_ff;
                  rsp_year_in  = year_ff;
                  rsp_wrap_in  = wrap_ff;
                  state_in     = S_IDLE;
               end
            end else begin
               cnt_in = cnt_ff - 1'b1;
               if (day_ff >= mlen) begin
                  day_in = gda_pkg::DAY_FIRST;
                  if (month_ff == gda_pkg::MONTH_DEC) begin
                     month_in = gda_pkg::MONTH_JAN;
                     year_in  = year_inc[YW-1:0];
                     wrap_in  = wrap_ff | year_inc[YW];
                     m25_in   = m25_next;
                  end else begin
                     month_in = month_ff + 1'b1;
                  end
               end else begin
                  day_in = day_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      day_ff       <= day_in;
      month_ff     <= month_in;
      year_ff      <= year_in;
      wrap_ff      <= wrap_in;
      midx_ff      <= midx_in;
      quot_ff      <= quot_in;
      m25_ff       <= m25_in;
      cnt_ff       <= cnt_in;
      rsp_day_ff   <= rsp_day_in;
      rsp_month_ff <= rsp_month_in;
      rsp_year_ff  <= rsp_year_in;
      rsp_wrap_ff  <= rsp_wrap_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_wrap_ff, rsp_year_ff, rsp_month_ff, rsp_day_ff};

   // checks
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP) |-> (month_ff >= gda_pkg::MONTH_JAN && month_ff <= gda_pkg::MONTH_DEC))
      else $error("month out of range while stepping");

   a_day_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP) |-> (day_ff != '0 && day_ff <= mlen))
      else $error("day outside month while stepping");

   a_m25_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP) |-> (m25_ff <= gda_pkg::M25_LAST))
      else $error("year mod 25 tracker out of range");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP && cnt_ff != '0) |=> (cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("day counter did not advance by one");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_MDIV))
      else $error("accepted beat did not start the sequencer");

endmodule
